// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication: whenever cond holds, prop must hold in the same cycle.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// ===== hdl/shb_pkg.sv =====
package shb_pkg;

  localparam int QueueDepth  = 4;
  localparam int DigestWords = 5;
  localparam int Rounds      = 80;
  localparam int BlockWords  = 16;

  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [5:0] LastPos   = 6'd63;
  localparam logic [7:0] PadMark   = 8'h80;

  localparam logic [31:0] H_INIT [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Command carried on the input side.
  localparam logic CmdAbsorb = 1'b0;
  localparam logic CmdFinish = 1'b1;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } shb_item_t;

  typedef struct packed {
    logic                         load;
    logic [DigestWords-1:0][31:0] words;
  } shb_digest_t;

endpackage

// ===== hdl/shb_front.sv =====
`include "assert_macros.svh"

module shb_front #(
  parameter int QUEUE_DEPTH = shb_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // data_byte
  input  logic                s_axis_tuser,  // cmd
  output logic                item_valid,
  input  logic                item_ready,
  output shb_pkg::shb_item_t  item
);
  import shb_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  shb_item_t       queue [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;
  shb_item_t       in_item;

  assign s_axis_tready = (count != CW'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (count != '0);
  assign pop           = item_valid && item_ready;
  assign item          = queue[rd_ptr];

  // classify the beat
  always_comb begin
    in_item.finish = (s_axis_tuser == CmdFinish);
    in_item.data   = s_axis_tdata;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_queue_bound, count <= CW'(QUEUE_DEPTH), "queue count above depth")

endmodule

// ===== hdl/shb_core.sv =====
`include "assert_macros.svh"

module shb_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  shb_pkg::shb_item_t   item,
  input  logic                 out_busy,
  output shb_pkg::shb_digest_t digest
);
  import shb_pkg::*;

  typedef enum logic [1:0] {IDLE, PAD, ROUND, ADD} state_t;

  state_t                        state;
  logic [BlockWords-1:0][31:0]   blk;
  logic [31:0]                   wv [DigestWords];
  logic [31:0]                   chain [DigestWords];
  logic [31:0]                   sums [DigestWords];
  logic [5:0]                    pos;
  logic [63:0]                   bitcnt;
  logic [6:0]                    rnd;
  logic                          fin;
  logic                          final_blk;
  logic                          pop;
  logic [7:0]                    pad_byte;
  logic [2:0]                    len_idx;
  logic [31:0]                   f;
  logic [31:0]                   k;
  logic [31:0]                   t;
  logic [31:0]                   w_new;
  logic [31:0]                   w_mix;

  assign item_ready = (state == IDLE) && (!item.finish || !out_busy);
  assign pop        = item_valid && item_ready;

  // length bytes go out most significant first
  assign len_idx  = pos[2:0];
  assign pad_byte = (final_blk && pos >= LenOffset) ?
                    bitcnt[8*(3'd7 - len_idx) +: 8] : 8'h00;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (wv[1] & wv[2]) | (~wv[1] & wv[3]);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = wv[1] ^ wv[2] ^ wv[3];
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (wv[1] & wv[2]) | (wv[1] & wv[3]) | (wv[2] & wv[3]);
      k = K2;
    end else begin
      f = wv[1] ^ wv[2] ^ wv[3];
      k = K3;
    end
  end

  // blk[15] is the schedule word for the current round
  assign t     = {wv[0][26:0], wv[0][31:27]} + f + wv[4] + k + blk[BlockWords-1];
  assign w_mix = blk[2] ^ blk[7] ^ blk[13] ^ blk[15];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    for (int i = 0; i < DigestWords; i++) begin
      sums[i] = chain[i] + wv[i];
    end
  end

  always_comb begin
    digest.load = (state == ADD) && fin && final_blk;
    for (int i = 0; i < DigestWords; i++) begin
      digest.words[i] = sums[i];
    end
  end

  // block buffer and round registers
  always_ff @(posedge clk) begin
    case (state)
      IDLE: begin
        if (pop) begin
          blk <= {blk[BlockWords-1][23:0], blk[BlockWords-2:0],
                  item.finish ? PadMark : item.data};
        end
        for (int i = 0; i < DigestWords; i++) begin
          wv[i] <= chain[i];
        end
      end
      PAD: begin
        blk <= {blk[BlockWords-1][23:0], blk[BlockWords-2:0], pad_byte};
        for (int i = 0; i < DigestWords; i++) begin
          wv[i] <= chain[i];
        end
      end
      ROUND: begin
        blk   <= {blk[BlockWords-2:0], w_new};
        wv[0] <= t;
        wv[1] <= wv[0];
        wv[2] <= {wv[1][1:0], wv[1][31:2]};
        wv[3] <= wv[2];
        wv[4] <= wv[3];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      pos       <= '0;
      bitcnt    <= '0;
      rnd       <= '0;
      fin       <= 1'b0;
      final_blk <= 1'b0;
      for (int i = 0; i < DigestWords; i++) begin
        chain[i] <= H_INIT[i];
      end
    end else begin
      case (state)
        IDLE: begin
          if (pop) begin
            pos <= pos + 1'b1;
            rnd <= '0;
            if (!item.finish) begin
              bitcnt <= bitcnt + 64'd8;
            end else begin
              fin       <= 1'b1;
              final_blk <= (pos < LenOffset);
            end
            if (pos == LastPos) begin
              state <= ROUND;
            end else if (item.finish) begin
              state <= PAD;
            end
          end
        end
        PAD: begin
          pos <= pos + 1'b1;
          rnd <= '0;
          if (pos == LastPos) begin
            state <= ROUND;
          end
        end
        ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == 7'(Rounds - 1)) begin
            state <= ADD;
          end
        end
        ADD: begin
          if (fin && final_blk) begin
            // digest handed off: restart the chain for the next message
            for (int i = 0; i < DigestWords; i++) begin
              chain[i] <= H_INIT[i];
            end
            bitcnt    <= '0;
            fin       <= 1'b0;
            final_blk <= 1'b0;
            state     <= IDLE;
          end else begin
            for (int i = 0; i < DigestWords; i++) begin
              chain[i] <= sums[i];
            end
            if (fin) begin
              final_blk <= 1'b1;
              state     <= PAD;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_load_free, digest.load |-> !out_busy, "digest load while output busy")
  `ASSERT_CLK(a_round_aligned, (state == ROUND) |-> (pos == 6'd0), "rounds on partial block")
  `ASSERT_CLK(a_pad_in_finish, (state == PAD) |-> fin, "padding outside a finish")

endmodule

// ===== hdl/shb_out.sv =====
`include "assert_macros.svh"

module shb_out (
  input  logic                 clk,
  input  logic                 rst,
  input  shb_pkg::shb_digest_t digest,
  output logic                 busy,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // digest_word, word_index, zero fill
  output logic                 m_axis_tlast   // last_word
);
  import shb_pkg::*;

  logic [31:0] words [DigestWords];
  logic [2:0]  cnt;
  logic [2:0]  word_index;
  logic        take;

  assign busy          = (cnt != '0);
  assign m_axis_tvalid = busy;
  assign take          = m_axis_tvalid && m_axis_tready;
  assign word_index    = 3'(DigestWords) - cnt;
  assign m_axis_tdata  = {5'd0, word_index, words[0]};
  assign m_axis_tlast  = (cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (digest.load) begin
      for (int i = 0; i < DigestWords; i++) begin
        words[i] <= digest.words[i];
      end
    end else if (take) begin
      // advance to the next word
      for (int i = 0; i < DigestWords - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (digest.load) begin
      cnt <= 3'(DigestWords);
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  `ASSERT_IMPL(a_load_when_empty, digest.load, cnt == 3'd0, "digest overwritten")

endmodule

// ===== hdl/sha1_byte_stream_hash_unit.sv =====
// SHA-1 over a byte stream.
// Input beats (s_axis): tuser is the command, 0 absorbs tdata as the next
// message byte, 1 finishes the message (tdata is ignored). Output beats
// (m_axis): five digest words, most significant first; tdata carries the
// word and its index, tlast marks the fifth.
// Input beats land in a short queue; the hash engine drains it. The engine
// takes an absorb beat while idle, and every 64th one completes a block and
// starts compression: 80 rounds, one round per cycle, then an addition into
// the chaining words; the engine takes no beats from the queue meanwhile.
// A finish pads byte by byte up to the block end and compresses that block;
// when the length no longer fits, a second block is padded and compressed.
// The first digest word is valid the cycle after the last addition.
// The digest sits in an output register and shifts out one word per beat.
// A receiver stall holds it there; absorb beats keep flowing meanwhile, and
// a following finish waits in the queue until the last word is taken.
// After the digest is handed off the chaining words, length and fill return
// to the initial values. Reset (rst, synchronous) empties the queue and the
// output and restores the initial hash values.
module sha1_byte_stream_hash_unit #(
  parameter int QUEUE_DEPTH = shb_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // digest_word [31:0], word_index [34:32], zeros
  output logic        m_axis_tlast   // last_word
);
  import shb_pkg::*;

  logic        item_valid;
  logic        item_ready;
  shb_item_t   item;
  logic        out_busy;
  shb_digest_t digest;

  shb_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  shb_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_busy   (out_busy),
    .digest     (digest)
  );

  shb_out u_out (
    .clk           (clk),
    .rst           (rst),
    .digest        (digest),
    .busy          (out_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== tb/sha1_digest_checker.sv =====
`timescale 1ns / 100ps

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // digest_word [31:0], word_index [34:32], zeros
  input  logic        m_axis_tlast,   // last_word
  output int          mismatches,
  output int          outstanding
);
  import shb_pkg::*;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain [DigestWords];
  logic [7:0]   msg_block [64];
  logic [5:0]   fill;
  logic [63:0]  bit_count;
  digest_beat_t digest_q [$];
  int           fail_tally = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void restart_chain();
    for (int i = 0; i < DigestWords; i++) chain[i] = H_INIT[i];
    fill      = '0;
    bit_count = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int i;
    for (i = 0; i < BlockWords; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (i = BlockWords; i < Rounds; i++) begin
      x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (i = 0; i < Rounds; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Pad the message, run the final block(s) and queue the five digest words.
  function automatic void finish_message();
    digest_beat_t beat;
    int pos;
    pos = int'(fill);
    msg_block[pos] = PadMark;
    pos++;
    if (pos > int'(LenOffset)) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < int'(LenOffset)) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++)
      msg_block[int'(LenOffset) + i] = bit_count[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < DigestWords; i++) begin
      beat.word  = chain[i];
      beat.index = 3'(i);
      beat.last  = (i == DigestWords - 1);
      digest_q.push_back(beat);
    end
    restart_chain();
  endfunction

  initial begin
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    restart_chain();
  end

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      restart_chain();
      digest_q.delete();
    end else begin
      // Results first: a beat leaving now never belongs to a finish taken now.
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest beat: word %h index %0d last %b",
                 m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
          fail_tally++;
        end else begin
          want = digest_q.pop_front();
          if (m_axis_tdata[31:0] !== want.word) begin
            $error("digest_word: expected %h, got %h", want.word, m_axis_tdata[31:0]);
            fail_tally++;
          end
          if (m_axis_tdata[34:32] !== want.index) begin
            $error("word_index: expected %0d, got %0d", want.index, m_axis_tdata[34:32]);
            fail_tally++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_word: expected %b, got %b", want.last, m_axis_tlast);
            fail_tally++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CmdFinish) begin
          finish_message();
        end else begin
          msg_block[fill] = s_axis_tdata;
          bit_count += 64'd8;
          fill = fill + 6'd1;
          if (fill == 6'd0) compress_block();
        end
      end
    end
    mismatches  <= fail_tally;
    outstanding <= digest_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import shb_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int ItemTarget = 380;
  localparam int CalmFrom   = 320;
  localparam int DrainWait  = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
  logic        s_axis_tuser = CmdAbsorb; // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // digest_word [31:0], word_index [34:32], zeros
  logic        m_axis_tlast;           // last_word

  int mismatches;
  int outstanding;
  int beats_sent = 0;
  int msg_count  = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha1_byte_stream_hash_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  sha1_digest_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall in random bursts, none once the run is calm.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [7:0] value);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
    if (beats_sent >= CalmFrom) calm = 1'b1;
  endtask

  // Hold the input idle until every digest word has been taken.
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len);
    logic [7:0] value;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       value = 8'h00;
        1:       value = 8'hFF;
        default: value = 8'($urandom_range(0, 255));
      endcase
      send_beat(CmdAbsorb, value);
    end
    send_beat(CmdFinish, 8'($urandom_range(0, 255)));
    msg_count++;
  endtask

  // Mostly short messages; the rest sit on the padding boundaries.
  function automatic int pick_length();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 55;
      2:       return 56;
      3:       return 63;
      4:       return 64;
      5:       return $urandom_range(57, 62);
      6:       return 119 + $urandom_range(0, 2);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  initial begin
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty message, data byte on the finish beat is ignored.
    send_beat(CmdFinish, 8'hFF);
    // "abc"
    send_beat(CmdAbsorb, 8'h61);
    send_beat(CmdAbsorb, 8'h62);
    send_beat(CmdAbsorb, 8'h63);
    send_beat(CmdFinish, 8'h00);
    // Byte extremes, then back-to-back finishes.
    send_beat(CmdAbsorb, 8'h00);
    send_beat(CmdAbsorb, 8'hFF);
    send_beat(CmdFinish, 8'h5A);
    send_beat(CmdFinish, 8'hA5);
    hold_until_drained();

    while (beats_sent < ItemTarget) begin
      // keep the last message inside the beat budget
      len = pick_length();
      if (len > ItemTarget - beats_sent - 1) len = ItemTarget - beats_sent - 1;
      send_message(len);
      if (msg_count % 4 == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sha1_byte_stream_hash_unit.f =====
+incdir+hdl
hdl/shb_pkg.sv
hdl/shb_front.sv
hdl/shb_core.sv
hdl/shb_out.sv
hdl/sha1_byte_stream_hash_unit.sv
tb/sha1_digest_checker.sv
tb/tb.sv
